// File: design/log_binned_power_spectrum_core_defines.svh
// assertion macros for the log-binned power spectrum block
`ifndef LOG_BINNED_POWER_SPECTRUM_CORE_DEFINES_SVH
`define LOG_BINNED_POWER_SPECTRUM_CORE_DEFINES_SVH
// implication checked at every clock edge outside reset
`define LBPS_ASSERT_IMPL(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define LBPS_ASSERT_NEXT(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: design/lbps_pkg.sv
// shared types and constants for the log-binned power spectrum block
package lbps_pkg;
   localparam int GridSizeDefault = 256;
   localparam int NumBinsDefault  = 2048;
   localparam int LogFrac         = 24;
   localparam int BinW            = 11;
   localparam int CountW          = 25;
   localparam int SumW            = 64;

   localparam logic [1:0] OP_ACCUM = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         grid_x;
      logic [7:0]         grid_y;
      logic [7:0]         grid_z;
      logic signed [31:0] coef_real;
      logic signed [31:0] coef_imag;
      logic [10:0]        read_bin;
   } req_type;

   typedef struct packed {
      logic [10:0] bin_used;
      logic        in_range;
      logic [63:0] power_sum;
      logic [24:0] mode_count;
      logic [63:0] power_mean;
   } rsp_type;

   // classified transaction from front to back
   typedef struct packed {
      logic [1:0]  op;
      logic        hit;
      logic [10:0] bin;
      logic [31:0] mag_re;
      logic [31:0] mag_im;
      logic [31:0] k2;
   } cmd_type;
endpackage

// File: design/log_binned_power_spectrum_core.sv
// accumulate: 24-step log by repeated squaring, then a bin divide that estimates and corrects
// read: 64-step mean division, skipped on an empty bin; misses and op 3 answer directly; clear sweeps first
// front takes one transaction at a time and stalls requests until it has passed it on; queue of two between
// reset: synchronous; after reset the back end sweeps every bin, zeroing it,
// and takes no transaction until done; count_enable resets to 1
module log_binned_power_spectrum_core #(
   parameter int GridSize = lbps_pkg::GridSizeDefault,
   parameter int NumBins  = lbps_pkg::NumBinsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lbps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lbps_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import lbps_pkg::*;

   logic    count_enable_ff;
   logic    f_valid, f_stall, b_valid, b_stall;
   cmd_type f_data, b_data;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         count_enable_ff <= csr_wr_data;
      end
   end

   lbps_front #(.GridSize(GridSize), .NumBins(NumBins)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .cmd_valid(f_valid), .cmd_stall(f_stall), .cmd_data(f_data));

   lbps_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_stall(f_stall),
      .in_data(f_data), .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data));

   lbps_back #(.NumBins(NumBins)) u_back (
      .clock(clock), .reset(reset), .count_enable(count_enable_ff),
      .cmd_valid(b_valid), .cmd_stall(b_stall), .cmd_data(b_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));
endmodule

// File: design/lbps_ram.sv
// generic single-port-write, single-port-read ram with registered read
module lbps_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// File: design/lbps_front.sv
// front end: folds indices, forms k2 and coefficient magnitudes, finds the bin
module lbps_front #(
   parameter int GridSize = lbps_pkg::GridSizeDefault,
   parameter int NumBins  = lbps_pkg::NumBinsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lbps_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_stall,
   output lbps_pkg::cmd_type cmd_data
);
   import lbps_pkg::*;

   function automatic logic [4:0] top_bit(input logic [31:0] v);
      logic [4:0] e;
      e = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            e = 5'(i);
         end
      end
      return e;
   endfunction

   // fixed-point log2, used at elaboration for the grid-size constants
   function automatic logic [31:0] log2_fix(input logic [31:0] v);
      logic [63:0] y;
      logic [31:0] frac;
      logic [4:0]  e;
      frac = '0;
      e = top_bit(v);
      y = 64'(v) << (5'd31 - e);
      for (int i = 0; i < LogFrac; i++) begin
         y = (y * y) >> 31;
         if (y[32]) begin
            y = y >> 1;
            frac[LogFrac-1-i] = 1'b1;
         end
      end
      return (32'(e) << LogFrac) | frac;
   endfunction

   localparam int Half = GridSize / 2;
   localparam logic [31:0] N2 = 32'(GridSize * GridSize);
   localparam logic [31:0] LimK2 = 32'(Half * Half);
   // log2 of (N/2)^2 and the scaled reciprocal of it
   localparam logic [31:0] Ld = log2_fix(N2) - (32'd2 << LogFrac);
   localparam logic [31:0] Recip = 32'((64'(NumBins) << 32) / 64'(Ld));

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOG  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [32:0] y_ff, y_in;
   logic [31:0] lk_ff, lk_in;
   logic [12:0] quo_ff, quo_in;

   function automatic logic [8:0] fold_abs(input logic [7:0] i);
      logic [8:0] v;
      v = {1'b0, i};
      if (v > 9'(Half)) begin
         v = 9'(GridSize) - v;
      end
      return v;
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   logic [8:0]  ax, ay, az;
   logic [31:0] k2_new;
   logic        idx_ok;
   logic [4:0]  e_new;
   logic [65:0] sq;
   logic [34:0] y_next;
   logic [63:0] prod;
   logic [47:0] num, chk;
   logic [12:0] quo_fix;

   always_comb begin
      ax = fold_abs(req_data.grid_x);
      ay = fold_abs(req_data.grid_y);
      az = fold_abs(req_data.grid_z);
      k2_new = 32'(ax) * 32'(ax) + 32'(ay) * 32'(ay) + 32'(az) * 32'(az);
      idx_ok = ({1'b0, req_data.grid_x} < 9'(GridSize)) &&
               ({1'b0, req_data.grid_y} < 9'(GridSize)) &&
               ({1'b0, req_data.grid_z} < 9'(GridSize));
      e_new = top_bit(k2_new);
      sq = 66'(y_ff) * 66'(y_ff);
      y_next = 35'(sq >> 31);
      // quotient estimate is exact or one short
      prod = 64'(lk_ff) * 64'(Recip);
      num = 48'(NumBins) * 48'(lk_ff);
      chk = 48'(quo_ff + 13'd1) * 48'(Ld);
      quo_fix = (num >= chk) ? quo_ff + 13'd1 : quo_ff;
   end

   // sequencer: for accumulate hits, log by repeated squaring, then reciprocal bin division; other ops go straight out
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      cnt_in   = cnt_ff;
      y_in     = y_ff;
      lk_in    = lk_ff;
      quo_in   = quo_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in.op     = req_data.op;
               cmd_in.bin    = (req_data.op == OP_READ) ? req_data.read_bin : '0;
               cmd_in.hit    = (req_data.op == OP_ACCUM) && idx_ok &&
                               (k2_new != 0) && (k2_new < LimK2);
               cmd_in.mag_re = mag32(req_data.coef_real);
               cmd_in.mag_im = mag32(req_data.coef_imag);
               cmd_in.k2     = k2_new;
               if ((req_data.op == OP_ACCUM) && cmd_in.hit) begin
                  state_in = S_LOG;
                  cnt_in   = '0;
                  y_in     = 33'(k2_new) << (5'd31 - e_new);
                  lk_in    = 32'(e_new) << LogFrac;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_LOG: begin
            // one fraction bit per squaring
            if (y_next[32]) begin
               y_in = y_next[33:1];
               lk_in[LogFrac-1-int'(cnt_ff)] = 1'b1;
            end else begin
               y_in = y_next[32:0];
            end
            if (cnt_ff == 5'(LogFrac - 1)) begin
               state_in = S_DIV;
               cnt_in   = 5'd1;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_DIV: begin
            // estimate first, then correct and clamp
            if (cnt_ff != '0) begin
               quo_in = 13'(prod >> 32);
               cnt_in = '0;
            end else begin
               state_in = S_OUT;
               if (quo_fix >= 13'(NumBins)) begin
                  cmd_in.bin = 11'(NumBins - 1);
               end else begin
                  cmd_in.bin = quo_fix[10:0];
               end
            end
         end
         S_OUT: begin
            if (!cmd_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff <= cmd_in;
      cnt_ff <= cnt_in;
      y_ff   <= y_in;
      lk_ff  <= lk_in;
      quo_ff <= quo_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign cmd_valid = (state_ff == S_OUT);
   assign cmd_data  = cmd_ff;
endmodule

// File: design/lbps_queue.sv
// two-entry queue between front and back
module lbps_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  lbps_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_stall,
   output lbps_pkg::cmd_type out_data
);
   import lbps_pkg::*;

   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   // pointer and fill bookkeeping
   always_comb begin
      wp_in   = push ? ~wp_ff : wp_ff;
      rp_in   = pop ? ~rp_ff : rp_ff;
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end

   assign in_stall  = (fill_ff == 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
endmodule

// File: design/lbps_back.sv
// back end: bin memories, accumulate, read with mean, clear sweep
module lbps_back #(
   parameter int NumBins = lbps_pkg::NumBinsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              count_enable,
   input  logic              cmd_valid,
   output logic              cmd_stall,
   input  lbps_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lbps_pkg::rsp_type rsp_data
);
   import lbps_pkg::*;

   localparam int AW = $clog2(NumBins);
   localparam logic [2:0] S_CLR   = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_WR    = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]    state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [AW:0]   clr_ff, clr_in;
   logic [63:0]   pre_ff, pre_in, pim_ff, pim_in;
   logic [6:0]    dc_ff, dc_in;
   logic [63:0]   q_ff, q_in;
   logic [24:0]   r_ff, r_in;
   rsp_type       rsp_ff, rsp_in;

   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [63:0]   wsum, rsum;
   logic [24:0]   wcnt, rcnt;

   lbps_ram #(.Width(64), .Depth(NumBins)) u_sum (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wsum),
      .rd_addr(raddr), .rd_data(rsum));
   lbps_ram #(.Width(25), .Depth(NumBins)) u_cnt (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wcnt),
      .rd_addr(raddr), .rd_data(rcnt));

   logic [64:0] psum, asum;
   logic [25:0] rsh;
   logic        bin_ok;

   always_comb begin
      psum   = {1'b0, pre_ff} + {1'b0, pim_ff};
      asum   = {1'b0, rsum} + psum;
      rsh    = {r_ff, q_ff[63]};
      bin_ok = ({1'b0, cmd_data.bin} < 12'(NumBins));
      // address the incoming bin while idle so the registered read data is ready in the following state
      raddr  = (state_ff == S_IDLE) ? AW'(cmd_data.bin) : AW'(cmd_ff.bin);
   end

   // sequencer for one transaction at a time
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      clr_in   = clr_ff;
      pre_in   = pre_ff;
      pim_in   = pim_ff;
      dc_in    = dc_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      rsp_in   = rsp_ff;
      we       = 1'b0;
      waddr    = clr_ff[AW-1:0];
      wsum     = '0;
      wcnt     = '0;
      unique case (state_ff)
         S_CLR: begin
            we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(NumBins - 1)) begin
               // a clear transaction answers, the reset sweep does not
               state_in = (cmd_ff.op == OP_CLEAR) ? S_OUT : S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd_data;
               rsp_in = '0;
               case (cmd_data.op)
                  OP_ACCUM: begin
                     if (cmd_data.hit) begin
                        rsp_in.bin_used = cmd_data.bin;
                        rsp_in.in_range = 1'b1;
                        state_in = S_MUL;
                     end else begin
                        state_in = S_OUT;
                     end
                  end
                  OP_READ: begin
                     rsp_in.bin_used = cmd_data.bin;
                     if (bin_ok) begin
                        rsp_in.in_range = 1'b1;
                        state_in = S_RD;
                     end else begin
                        state_in = S_OUT;
                     end
                  end
                  OP_CLEAR: begin
                     clr_in = '0;
                     state_in = S_CLR;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_MUL: begin
            // squares registered before the sum, memory read in flight
            pre_in = 64'(cmd_ff.mag_re) * 64'(cmd_ff.mag_re);
            pim_in = 64'(cmd_ff.mag_im) * 64'(cmd_ff.mag_im);
            state_in = S_WR;
         end
         S_WR: begin
            we = 1'b1;
            waddr = AW'(cmd_ff.bin);
            wsum = asum[64] ? '1 : asum[63:0];
            wcnt = (count_enable && (rcnt != '1)) ? rcnt + 25'd1 : rcnt;
            state_in = S_OUT;
         end
         S_RD: begin
            rsp_in.power_sum  = rsum;
            rsp_in.mode_count = rcnt;
            q_in  = rsum;
            r_in  = '0;
            dc_in = 7'd64;
            state_in = (rcnt == '0) ? S_OUT : S_DIV;
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            q_in = {q_ff[62:0], 1'b0};
            if (rsh >= {1'b0, rsp_ff.mode_count}) begin
               r_in = 25'(rsh - {1'b0, rsp_ff.mode_count});
               q_in[0] = 1'b1;
            end else begin
               r_in = rsh[24:0];
            end
            dc_in = dc_ff - 7'd1;
            if (dc_ff == 7'd1) begin
               rsp_in.power_mean = q_in;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         cmd_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cmd_ff   <= cmd_in;
      end
      pre_ff <= pre_in;
      pim_ff <= pim_in;
      dc_ff  <= dc_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      rsp_ff <= rsp_in;
   end

   assign cmd_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;
endmodule

// File: design/lbps_checker.sv
// port-level checker for the log-binned power spectrum block
`include "log_binned_power_spectrum_core_defines.svh"
module lbps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input lbps_pkg::rsp_type rsp_data,
   input logic              rsp_valid,
   input logic              rsp_stall
);
   `LBPS_ASSERT_NEXT(req_hold, reset, req_valid && req_stall, req_valid, "req dropped while stalled")
   `LBPS_ASSERT_NEXT(rsp_hold, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp changed while stalled")
   `LBPS_ASSERT_IMPL(empty_bin_mean, reset, rsp_valid && rsp_data.mode_count == 0, rsp_data.power_mean == 0, "nonzero mean on empty bin")
   `LBPS_ASSERT_IMPL(mean_le_sum, reset, rsp_valid, rsp_data.power_mean <= rsp_data.power_sum, "mean exceeds sum")
   `LBPS_ASSERT_IMPL(out_range_zero, reset, rsp_valid && !rsp_data.in_range, rsp_data.power_sum == 0 && rsp_data.mode_count == 0, "data on miss")
endmodule

bind log_binned_power_spectrum_core lbps_checker u_lbps_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_data(rsp_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall));

// File: tb/sv/testbench.sv
// self-checking testbench for the log-binned power spectrum core
module testbench;
   import lbps_pkg::*;

   localparam int NBins       = NumBinsDefault;
   localparam int GridN       = GridSizeDefault;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [63:0] SumMax   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [24:0] CountMax = 25'h1FF_FFFF;
   localparam int CycleLimit  = 8000000;
   localparam int ReqW        = $bits(req_type);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic    csr_wr_data = 1'b0;

   // spectrum model state
   logic [63:0] power_bins [NBins];
   logic [24:0] count_bins [NBins];
   logic        count_on;
   rsp_type     pending_rsps [$];
   logic [10:0] last_bin;

   int  mismatches = 0;
   int  cycles = 0;
   bit  idle_on = 1'b1;
   bit  hold_on = 1'b0;
   int  stall_left = 0;

   log_binned_power_spectrum_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // run length guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // fixed-point log2: integer part from top bit, fraction by repeated squaring
   function automatic logic [63:0] log2_fixed(logic [31:0] v);
      int          e;
      logic [63:0] y;
      logic [63:0] frac;
      e = 0;
      frac = '0;
      if (v == 0) return '0;
      while (e < 31 && (v >> (e + 1)) != 0) e++;
      y = {32'b0, v} << (31 - e);
      for (int i = 0; i < LogFrac; i++) begin
         y = (y * y) >> 31;
         if (y >= 64'h1_0000_0000) begin
            y = y >> 1;
            frac[LogFrac - 1 - i] = 1'b1;
         end
      end
      return (64'(e) << LogFrac) | frac;
   endfunction

   function automatic int fold_wavenumber(logic [7:0] i);
      return (int'(i) > GridN / 2) ? int'(i) - GridN : int'(i);
   endfunction

   function automatic logic [63:0] coef_magnitude(logic [31:0] c);
      return c[31] ? (64'h1_0000_0000 - {32'b0, c}) : {32'b0, c};
   endfunction

   // spectrum predictor: updates the model bins and returns the expected response
   function automatic rsp_type predict_spectrum(req_type r);
      rsp_type     o;
      int          kx, ky, kz;
      logic [31:0] k2;
      logic [63:0] num, den, bin, pw, re, im;
      o = '0;
      if (r.op == OP_ACCUM) begin
         kx = fold_wavenumber(r.grid_x);
         ky = fold_wavenumber(r.grid_y);
         kz = fold_wavenumber(r.grid_z);
         k2 = kx * kx + ky * ky + kz * kz;
         if (k2 != 0 && 4 * k2 < GridN * GridN) begin
            num = 64'(NBins) * log2_fixed(k2);
            den = log2_fixed(GridN * GridN) - (64'd2 << LogFrac);
            bin = (den != 0) ? num / den : 64'd0;
            if (bin >= 64'(NBins)) bin = 64'(NBins - 1);
            re = coef_magnitude(r.coef_real);
            im = coef_magnitude(r.coef_imag);
            pw = re * re + im * im;
            if (power_bins[bin] > SumMax - pw) power_bins[bin] = SumMax;
            else power_bins[bin] = power_bins[bin] + pw;
            if (count_on && count_bins[bin] < CountMax)
               count_bins[bin] = count_bins[bin] + 25'd1;
            o.bin_used = bin[10:0];
            o.in_range = 1'b1;
         end
      end else if (r.op == OP_READ) begin
         o.bin_used = r.read_bin;
         if (int'(r.read_bin) < NBins) begin
            o.in_range   = 1'b1;
            o.power_sum  = power_bins[r.read_bin];
            o.mode_count = count_bins[r.read_bin];
            o.power_mean = (count_bins[r.read_bin] != 0) ?
                           power_bins[r.read_bin] / {39'b0, count_bins[r.read_bin]} : 64'd0;
         end
      end else if (r.op == OP_CLEAR) begin
         for (int i = 0; i < NBins; i++) begin
            power_bins[i] = '0;
            count_bins[i] = '0;
         end
      end
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      mismatches++;
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(rsp_data.bin_used), 64'd0);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_data.bin_used !== want.bin_used)
               report_mismatch("bin_used", 64'(rsp_data.bin_used), 64'(want.bin_used));
            if (rsp_data.in_range !== want.in_range)
               report_mismatch("in_range", 64'(rsp_data.in_range), 64'(want.in_range));
            if (rsp_data.power_sum !== want.power_sum)
               report_mismatch("power_sum", rsp_data.power_sum, want.power_sum);
            if (rsp_data.mode_count !== want.mode_count)
               report_mismatch("mode_count", 64'(rsp_data.mode_count), 64'(want.mode_count));
            if (rsp_data.power_mean !== want.power_mean)
               report_mismatch("power_mean", rsp_data.power_mean, want.power_mean);
         end
      end
   end

   // receiver back-pressure: random stalls, plus the long hold-off
   always @(negedge clock) begin
      if (hold_on) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (idle_on && $urandom_range(0, 7) == 0)
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 100)
                                                       : $urandom_range(1, 3);
      end
   end

   function automatic int gap_length();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 80);
   endfunction

   // offer one transaction and wait for its acceptance
   task automatic send_item(req_type r);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      pending_rsps.push_back(predict_spectrum(r));
      if (r.op == OP_ACCUM && pending_rsps[$].in_range) last_bin = pending_rsps[$].bin_used;
   endtask

   // sender pauses until the block has drained
   task automatic wait_drained();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_count_enable(logic v);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      count_on = v;
   endtask

   function automatic req_type accum_item(logic [7:0] x, logic [7:0] y, logic [7:0] z,
                                          logic [31:0] re, logic [31:0] im);
      req_type r;
      r = req_type'(ReqW'({$urandom, $urandom, $urandom, $urandom}));
      r.op = OP_ACCUM;
      r.grid_x = x; r.grid_y = y; r.grid_z = z;
      r.coef_real = re; r.coef_imag = im;
      return r;
   endfunction

   function automatic req_type op_item(logic [1:0] op, logic [10:0] bin);
      req_type r;
      r = req_type'(ReqW'({$urandom, $urandom, $urandom, $urandom}));
      r.op = op;
      r.read_bin = bin;
      return r;
   endfunction

   // field extremes, folding edges, saturation, clear and the unused op
   task automatic test_directed();
      send_item(accum_item(8'd0, 8'd0, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF));
      send_item(accum_item(8'd128, 8'd0, 8'd0, 32'h1, 32'h1));
      send_item(accum_item(8'd129, 8'd0, 8'd0, 32'h7FFF_FFFF, 32'h0));
      send_item(accum_item(8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'h3));
      send_item(accum_item(8'd90, 8'd90, 8'd0, 32'h1234, 32'h8765));
      send_item(accum_item(8'd1, 8'd0, 8'd0, 32'h8000_0000, 32'h8000_0000));
      send_item(accum_item(8'd0, 8'd255, 8'd0, 32'h8000_0000, 32'h8000_0000));
      send_item(accum_item(8'd0, 8'd0, 8'd1, 32'h8000_0000, 32'h8000_0000));
      send_item(op_item(OP_READ, 11'd0));
      send_item(op_item(OP_READ, last_bin));
      send_item(op_item(OP_READ, 11'd2047));
      send_item(op_item(OP_UNUSED, 11'd0));
      send_item(op_item(OP_READ, 11'd0));
      send_item(op_item(OP_CLEAR, 11'd0));
      send_item(op_item(OP_READ, 11'd0));
      send_item(op_item(OP_READ, last_bin));
      wait_drained();
   endtask

   // sums grow while counts stay frozen, then counting resumes
   task automatic test_count_disabled();
      write_count_enable(1'b0);
      send_item(accum_item(8'd2, 8'd0, 8'd0, 32'h10, 32'h20));
      send_item(accum_item(8'd254, 8'd0, 8'd0, 32'hFFFF_FFF0, 32'h5));
      send_item(op_item(OP_READ, last_bin));
      write_count_enable(1'b1);
      send_item(accum_item(8'd0, 8'd2, 8'd0, 32'h7, 32'h9));
      send_item(op_item(OP_READ, last_bin));
      wait_drained();
   endtask

   // random traffic, mostly accumulates, with reads of the last used bin and of random bins, the unused op and clears
   task automatic test_random(int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 80)
            send_item(accum_item(8'($urandom), 8'($urandom), 8'($urandom),
                                 $urandom, $urandom));
         else if (sel < 90)
            send_item(op_item(OP_READ, last_bin));
         else if (sel < 97)
            send_item(op_item(OP_READ, 11'($urandom)));
         else if (sel < 99)
            send_item(op_item(OP_UNUSED, 11'($urandom)));
         else
            send_item(op_item(OP_CLEAR, 11'($urandom)));
      end
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      fork
         begin
            hold_on = 1'b1;
            repeat (400) @(posedge clock);
            hold_on = 1'b0;
         end
      join_none
      idle_on = 1'b0;
      for (int i = 0; i < 12; i++)
         send_item(accum_item(8'($urandom), 8'($urandom), 8'($urandom),
                              $urandom, $urandom));
      send_item(op_item(OP_READ, last_bin));
      idle_on = 1'b1;
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < NBins; i++) begin
         power_bins[i] = '0;
         count_bins[i] = '0;
      end
      count_on = 1'b1;
      last_bin = '0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_directed();
      test_count_disabled();
      test_backpressure();
      write_count_enable(1'b1);
      test_random(175);
      write_count_enable(1'b0);
      test_random(175);
      idle_on = 1'b0;
      write_count_enable(1'b1);
      test_random(175);
      idle_on = 1'b1;
      write_count_enable(1'b0);
      test_random(100);
      write_count_enable(1'b1);
      test_random(75);
      repeat (200) @(posedge clock);
      if (pending_rsps.size() != 0)
         report_mismatch("transactions left over", 64'(pending_rsps.size()), 64'd0);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
